>>> sv/oaht_pkg.sv
// shared types and constants of the open-address hash table
// no dependencies; every other file imports this package

package oaht_pkg;

    // table geometry and field widths
    localparam int unsigned SLOTS      = 256;
    localparam int unsigned SLOT_BITS  = $clog2(SLOTS);
    localparam int unsigned COUNT_BITS = SLOT_BITS + 1;
    localparam int unsigned KEY_BITS   = 32;
    localparam int unsigned VALUE_BITS = 32;
    localparam int unsigned HASH_BITS  = 32;
    localparam int unsigned KIND_BITS  = 2;
    localparam int unsigned STAT_BITS  = 3;

    // load rule: grow when 4 * count >= 3 * slots
    localparam int unsigned GROW_LIMIT = 3 * SLOTS;

    // request kinds
    typedef enum logic [KIND_BITS-1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    // response status codes
    typedef enum logic [STAT_BITS-1:0] {
        STAT_FOUND     = 3'd0,
        STAT_NOT_FOUND = 3'd1,
        STAT_INSERTED  = 3'd2,
        STAT_REPLACED  = 3'd3,
        STAT_DUPLICATE = 3'd4,
        STAT_FULL      = 3'd5
    } t_status;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_WRITE,
        S_RESP
    } t_state;

    // write-back action decided at the end of the probe sequence, or on acceptance for clear
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_INSERT,
        ACT_REPLACE,
        ACT_REMOVE,
        ACT_CLEAR
    } t_action;

    // one memory word; the live bit kept beside it tells empty from used
    typedef struct packed {
        logic                  tomb;
        logic [KEY_BITS-1:0]   key;
        logic [HASH_BITS-1:0]  hash;
        logic [VALUE_BITS-1:0] value;
    } t_entry;

    // control from the sequencer to the entry store
    typedef struct packed {
        logic                 rd_en;
        logic [SLOT_BITS-1:0] rd_addr;
        logic                 wr_en;
        logic [SLOT_BITS-1:0] wr_addr;
        logic                 clear_all;
    } t_store_ctl;

endpackage

>>> sv/oaht_if.sv
// valid/ready channel interfaces: request, response and configuration
// depends on oaht_pkg

interface oaht_req_if import oaht_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [KIND_BITS-1:0]  kind;
    logic [KEY_BITS-1:0]   key;
    logic [HASH_BITS-1:0]  hash;
    logic [VALUE_BITS-1:0] value;
    logic                  allow_replace;

    modport source (output valid, kind, key, hash, value, allow_replace, input ready);
    modport sink   (input valid, kind, key, hash, value, allow_replace, output ready);
endinterface

interface oaht_rsp_if import oaht_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [STAT_BITS-1:0]  status;
    logic [VALUE_BITS-1:0] found_value;
    logic [KEY_BITS-1:0]   stored_key;
    logic [SLOT_BITS-1:0]  slot_index;
    logic [COUNT_BITS-1:0] entry_count;
    logic                  needs_grow;

    modport source (output valid, status, found_value, stored_key, slot_index,
                    entry_count, needs_grow, input ready);
    modport sink   (input valid, status, found_value, stored_key, slot_index,
                    entry_count, needs_grow, output ready);
endinterface

interface oaht_cfg_if import oaht_pkg::*; ();
    logic valid;
    logic ready;
    logic probe_mode;

    modport source (output valid, probe_mode, input ready);
    modport sink   (input valid, probe_mode, output ready);
endinterface

>>> sv/open_address_hash_table_top.sv
// Open-address hash table of 256 slots with tombstones. Each request (lookup,
// insert, remove, clear) returns one response beat. A request probes 1 to 256
// slots: the probe walk reads one slot per cycle from the single entry memory,
// then a write-back step and a response step follow. Clear skips the probe
// walk. One request is in flight at a time; a new one is taken as soon as the
// previous response sits in the output register. Slot emptiness lives in flops
// that reset and clear empty at once, so no clearing pass follows reset. The
// probe mode register may be written whenever the table is idle.
// depends on oaht_pkg, oaht_if, oaht_store, oaht_ctrl

module open_address_hash_table_top import oaht_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    oaht_cfg_if.sink   i_cfg,
    oaht_req_if.sink   i_req,
    oaht_rsp_if.source o_rsp
);

    logic       r_probe_mode;
    t_store_ctl store_ctl;
    t_entry     wr_data;
    t_entry     rd_data;
    logic       rd_live;

    // probe mode register: 0 linear, 1 triangular
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe_mode <= 1'b0;
        end else if (i_cfg.valid) begin
            r_probe_mode <= i_cfg.probe_mode;
        end
    end

    // probe sequencer
    oaht_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_probe_mode (r_probe_mode),
        .i_req        (i_req),
        .o_rsp        (o_rsp),
        .o_store_ctl  (store_ctl),
        .o_wr_data    (wr_data),
        .i_rd_data    (rd_data),
        .i_rd_live    (rd_live)
    );

    // entry memory and live bits
    oaht_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (store_ctl),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data),
        .o_rd_live (rd_live)
    );

endmodule

>>> sv/oaht_store.sv
// entry store: one synchronous memory of key, hash, value and tombstone flag,
// plus a live bit per slot in flops; depends on oaht_pkg

module oaht_store import oaht_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_store_ctl i_ctl,
    input  t_entry     i_wr_data,
    output t_entry     o_rd_data,
    output logic       o_rd_live
);

    t_entry           r_mem [SLOTS];
    t_entry           r_rd_data;
    logic [SLOTS-1:0] r_live;
    logic             r_rd_live;

    // memory port: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_ctl.rd_addr];
        end
    end

    // live bits: cleared at once on reset or clear-all
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live    <= '0;
            r_rd_live <= 1'b0;
        end else begin
            if (i_ctl.clear_all) begin
                r_live <= '0;
            end else if (i_ctl.wr_en) begin
                r_live[i_ctl.wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_live <= r_live[i_ctl.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_live = r_rd_live;

endmodule

>>> sv/oaht_ctrl.sv
// probe sequencer: walks the probe sequence one slot per cycle, decides the
// write-back and holds the response register; depends on oaht_pkg, oaht_if

module oaht_ctrl import oaht_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_probe_mode,
    oaht_req_if.sink   i_req,
    oaht_rsp_if.source o_rsp,
    output t_store_ctl o_store_ctl,
    output t_entry     o_wr_data,
    input  t_entry     i_rd_data,
    input  logic       i_rd_live
);

    t_state                r_state, n_state;
    t_kind                 r_kind, n_kind;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [HASH_BITS-1:0]  r_hash, n_hash;
    logic [VALUE_BITS-1:0] r_value, n_value;
    logic                  r_repl, n_repl;
    logic [SLOT_BITS-1:0]  r_addr, n_addr;
    logic [SLOT_BITS-1:0]  r_probe, n_probe;
    logic                  r_tomb_seen, n_tomb_seen;
    logic [SLOT_BITS-1:0]  r_tomb, n_tomb;
    logic [COUNT_BITS-1:0] r_count, n_count;
    t_action               r_act, n_act;
    t_status               r_status, n_status;
    logic [VALUE_BITS-1:0] r_fval, n_fval;
    logic [KEY_BITS-1:0]   r_skey, n_skey;
    logic [SLOT_BITS-1:0]  r_sidx, n_sidx;
    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [VALUE_BITS-1:0] r_out_fval, n_out_fval;
    logic [KEY_BITS-1:0]   r_out_skey, n_out_skey;
    logic [SLOT_BITS-1:0]  r_out_sidx, n_out_sidx;
    logic [COUNT_BITS-1:0] r_out_count, n_out_count;
    logic                  r_out_grow, n_out_grow;

    // probe evaluation on the word just read
    logic                  slot_empty;
    logic                  slot_tomb;
    logic                  slot_hit;
    logic                  last_probe;
    logic                  tomb_any;
    logic [SLOT_BITS-1:0]  tomb_slot;
    logic [SLOT_BITS-1:0]  next_addr;
    logic [COUNT_BITS+1:0] count_x4;

    assign slot_empty = !i_rd_live;
    assign slot_tomb  = i_rd_live && i_rd_data.tomb;
    assign slot_hit   = i_rd_live && !i_rd_data.tomb && (i_rd_data.hash == r_hash)
                        && (i_rd_data.key == r_key);
    assign last_probe = (r_probe == SLOT_BITS'(SLOTS - 1));
    assign tomb_any   = r_tomb_seen || slot_tomb;
    assign tomb_slot  = r_tomb_seen ? r_tomb : r_addr;
    // linear: +1; triangular: step is probe number + 1
    assign next_addr  = r_addr + (i_probe_mode ? (r_probe + SLOT_BITS'(1)) : SLOT_BITS'(1));
    assign count_x4   = {r_count, 2'b00};

    assign i_req.ready = (r_state == S_IDLE);

    // state and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_kind       <= n_kind;
        r_key        <= n_key;
        r_hash       <= n_hash;
        r_value      <= n_value;
        r_repl       <= n_repl;
        r_addr       <= n_addr;
        r_probe      <= n_probe;
        r_tomb_seen  <= n_tomb_seen;
        r_tomb       <= n_tomb;
        r_act        <= n_act;
        r_status     <= n_status;
        r_fval       <= n_fval;
        r_skey       <= n_skey;
        r_sidx       <= n_sidx;
        r_out_status <= n_out_status;
        r_out_fval   <= n_out_fval;
        r_out_skey   <= n_out_skey;
        r_out_sidx   <= n_out_sidx;
        r_out_count  <= n_out_count;
        r_out_grow   <= n_out_grow;
    end

    // next state, store control and response
    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_key        = r_key;
        n_hash       = r_hash;
        n_value      = r_value;
        n_repl       = r_repl;
        n_addr       = r_addr;
        n_probe      = r_probe;
        n_tomb_seen  = r_tomb_seen;
        n_tomb       = r_tomb;
        n_count      = r_count;
        n_act        = r_act;
        n_status     = r_status;
        n_fval       = r_fval;
        n_skey       = r_skey;
        n_sidx       = r_sidx;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_fval   = r_out_fval;
        n_out_skey   = r_out_skey;
        n_out_sidx   = r_out_sidx;
        n_out_count  = r_out_count;
        n_out_grow   = r_out_grow;
        o_store_ctl  = '0;
        o_wr_data    = '0;

        // response beat taken
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_kind      = t_kind'(i_req.kind);
                    n_key       = i_req.key;
                    n_hash      = i_req.hash;
                    n_value     = i_req.value;
                    n_repl      = i_req.allow_replace;
                    n_addr      = i_req.hash[SLOT_BITS-1:0];
                    n_probe     = '0;
                    n_tomb_seen = 1'b0;
                    n_act       = ACT_NONE;
                    n_status    = STAT_NOT_FOUND;
                    n_fval      = '0;
                    n_skey      = '0;
                    n_sidx      = '0;
                    if (t_kind'(i_req.kind) == KIND_CLEAR) begin
                        n_act    = ACT_CLEAR;
                        n_status = STAT_FOUND;
                        n_state  = S_WRITE;
                    end else begin
                        // home slot read
                        o_store_ctl.rd_en   = 1'b1;
                        o_store_ctl.rd_addr = i_req.hash[SLOT_BITS-1:0];
                        n_state             = S_PROBE;
                    end
                end
            end

            S_PROBE: begin
                priority if (slot_empty) begin
                    // probe stops: miss, insert at first tombstone or here
                    if (r_kind == KIND_INSERT) begin
                        n_act    = ACT_INSERT;
                        n_status = STAT_INSERTED;
                        n_skey   = r_key;
                        n_sidx   = tomb_slot;
                    end
                    n_state = S_WRITE;
                end else if (slot_hit) begin
                    n_status = STAT_FOUND;
                    n_fval   = i_rd_data.value;
                    n_skey   = i_rd_data.key;
                    n_sidx   = r_addr;
                    if (r_kind == KIND_REMOVE) begin
                        n_act = ACT_REMOVE;
                    end else if (r_kind == KIND_INSERT) begin
                        if (r_repl) begin
                            n_act    = ACT_REPLACE;
                            n_status = STAT_REPLACED;
                            n_skey   = r_key;
                        end else begin
                            n_status = STAT_DUPLICATE;
                        end
                    end
                    n_state = S_WRITE;
                end else if (last_probe) begin
                    // every slot visited without an empty one
                    if (r_kind == KIND_INSERT) begin
                        if (tomb_any) begin
                            n_act    = ACT_INSERT;
                            n_status = STAT_INSERTED;
                            n_skey   = r_key;
                            n_sidx   = tomb_slot;
                        end else begin
                            n_status = STAT_FULL;
                        end
                    end
                    n_state = S_WRITE;
                end else begin
                    // keep probing; remember the first tombstone
                    if (slot_tomb && !r_tomb_seen) begin
                        n_tomb_seen = 1'b1;
                        n_tomb      = r_addr;
                    end
                    n_probe             = r_probe + SLOT_BITS'(1);
                    n_addr              = next_addr;
                    o_store_ctl.rd_en   = 1'b1;
                    o_store_ctl.rd_addr = next_addr;
                end
            end

            S_WRITE: begin
                o_store_ctl.wr_addr = r_sidx;
                unique case (r_act)
                    ACT_INSERT: begin
                        o_store_ctl.wr_en = 1'b1;
                        o_wr_data         = '{tomb: 1'b0, key: r_key, hash: r_hash,
                                              value: r_value};
                        n_count           = r_count + COUNT_BITS'(1);
                    end
                    ACT_REPLACE: begin
                        o_store_ctl.wr_en = 1'b1;
                        o_wr_data         = '{tomb: 1'b0, key: r_key, hash: r_hash,
                                              value: r_value};
                    end
                    ACT_REMOVE: begin
                        o_store_ctl.wr_en = 1'b1;
                        o_wr_data         = '{tomb: 1'b1, key: r_skey, hash: r_hash,
                                              value: r_fval};
                        if (r_count != '0) begin
                            n_count = r_count - COUNT_BITS'(1);
                        end
                    end
                    ACT_CLEAR: begin
                        o_store_ctl.clear_all = 1'b1;
                        n_count               = '0;
                    end
                    default: begin
                    end
                endcase
                n_state = S_RESP;
            end

            S_RESP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_fval   = r_fval;
                    n_out_skey   = r_skey;
                    n_out_sidx   = r_sidx;
                    n_out_count  = r_count;
                    n_out_grow   = (count_x4 >= (COUNT_BITS + 2)'(GROW_LIMIT));
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.found_value = r_out_fval;
    assign o_rsp.stored_key  = r_out_skey;
    assign o_rsp.slot_index  = r_out_sidx;
    assign o_rsp.entry_count = r_out_count;
    assign o_rsp.needs_grow  = r_out_grow;

endmodule

>>> sv/oaht_checker.sv
// port-level checks on the hash table's request and response channels,
// bound to open_address_hash_table_top; depends on oaht_pkg

module oaht_checker import oaht_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_req_valid,
    input logic                  i_req_ready,
    input logic                  i_rsp_valid,
    input logic [STAT_BITS-1:0]  i_rsp_status,
    input logic [COUNT_BITS-1:0] i_rsp_count,
    input logic                  i_rsp_grow
);

    // one request in flight: an accepted beat closes the request side
    a_single_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request accepted while another is in flight");

    // occupancy never exceeds the slot count
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_count <= COUNT_BITS'(SLOTS)))
        else $error("entry count beyond capacity");

    // grow flag follows the three-quarter rule on the reported count
    a_grow_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_grow ==
            ({i_rsp_count, 2'b00} >= (COUNT_BITS + 2)'(GROW_LIMIT))))
        else $error("needs_grow disagrees with entry count");

    // an insert always leaves at least one entry
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status == STAT_INSERTED)) |-> (i_rsp_count != '0))
        else $error("insert reported with empty table");

    // status code stays within the defined set
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_status <= STAT_FULL))
        else $error("undefined status code");

endmodule

bind open_address_hash_table_top oaht_checker u_oaht_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_status (o_rsp.status),
    .i_rsp_count  (o_rsp.entry_count),
    .i_rsp_grow   (o_rsp.needs_grow)
);
